// ----- sv/cod_pkg.sv -----
// Shared types and constants for the curvature oscillation detector.
`default_nettype none
package cod_pkg;

  localparam int CFG_BITS      = 3;
  localparam int LINE_POS_BITS = 3;

  localparam logic [LINE_POS_BITS-1:0] POS_CURVE = LINE_POS_BITS'(3);
  localparam logic [LINE_POS_BITS-1:0] POS_CHECK = LINE_POS_BITS'(5);
  localparam logic [LINE_POS_BITS-1:0] POS_MAX   = LINE_POS_BITS'(6);

  localparam logic [CFG_BITS-1:0] COUNT_RESET = CFG_BITS'(1);

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_t;

  typedef struct packed {
    logic accept;
    logic curve_en;
    logic check_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
  } merge_ctrl_t;

endpackage
`default_nettype wire

// ----- sv/cod_lane.sv -----
// One substance lane: sample history, curvature sign history and pattern check.
`default_nettype none
module cod_lane
  import cod_pkg::*;
#(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                   clk,
  input  wire lane_ctrl_t             ctrl,
  input  wire logic                   enable,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic                        hit
);

  localparam int DIFF_BITS = SAMPLE_BITS + 2;

  logic [SAMPLE_BITS-1:0] back_one;
  logic [SAMPLE_BITS-1:0] back_two;
  sign_t                  sign_one;
  sign_t                  sign_two;

  logic signed [DIFF_BITS-1:0] ext_c;
  logic signed [DIFF_BITS-1:0] ext_a;
  logic signed [DIFF_BITS-1:0] ext_b;
  logic signed [DIFF_BITS-1:0] diff;
  sign_t                       sign_new;
  logic                        up;
  logic                        down;

  always_comb begin
    ext_c = $signed({{2{sample[SAMPLE_BITS-1]}}, sample});
    ext_a = $signed({{2{back_two[SAMPLE_BITS-1]}}, back_two});
    ext_b = $signed({back_one[SAMPLE_BITS-1], back_one, 1'b0});
    diff  = ext_a + ext_c - ext_b;
    if (diff == '0) begin
      sign_new = SIGN_ZERO;
    end else if (diff[DIFF_BITS-1]) begin
      sign_new = SIGN_NEG;
    end else begin
      sign_new = SIGN_POS;
    end
    up   = (sign_two != SIGN_NEG) && (sign_one == SIGN_NEG) && (sign_new != SIGN_NEG);
    down = (sign_two != SIGN_POS) && (sign_one == SIGN_POS) && (sign_new != SIGN_POS);
    hit  = ctrl.check_en && enable && (up || down);
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      back_two <= back_one;
      back_one <= sample;
      if (ctrl.curve_en) begin
        sign_two <= sign_one;
        sign_one <= sign_new;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/cod_merge.sv -----
// Merges lane hits: priority pick, sticky flag and the output register.
`default_nettype none
module cod_merge
  import cod_pkg::*;
#(
  parameter int LANES     = 4,
  parameter int LANE_BITS = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire merge_ctrl_t          ctrl,
  input  wire logic [LANES-1:0]     hits,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic                      out_found_here,
  output logic                      out_found_any,
  output logic [LANE_BITS-1:0]      out_first_lane
);

  logic                 sticky;
  logic                 sticky_next;
  logic                 found;
  logic [LANE_BITS-1:0] first;

  always_comb begin
    first = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (hits[l]) begin
        first = LANE_BITS'(l);
      end
    end
    found       = |hits;
    sticky_next = (sticky && !ctrl.scan_start) || found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sticky    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.accept) begin
        sticky    <= sticky_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      out_found_here <= found;
      out_found_any  <= sticky_next;
      out_first_lane <= first;
    end
  end

endmodule
`default_nettype wire

// ----- sv/curvature_oscillation_detector.sv -----
// Top level of the curvature oscillation detector.
//
// Each input request on the s_axis channel is one grid point holding one
// signed sample per lane, plus line_start and scan_start flags in tuser.
// Every lane keeps its last two samples and last two curvature signs and
// checks the sign pattern from the sixth point of a line on; a merge
// stage picks the lowest hitting lane and keeps the sticky flag.
// Each input request yields exactly one output request on m_axis, in the
// cycle after it is accepted, from an output register.
// Throughput is one point per cycle: s_axis_tready is high whenever the
// output register is empty or is being drained in the same cycle, so a
// stalled receiver holds the result and blocks new input only then.
// The cfg channel writes substance_count (lanes checked); it is always
// ready and must only be written while the block is idle.
// Reset clears the line position, the sticky flag and the output valid,
// and sets substance_count to 1; sample and sign history is not cleared.
`default_nettype none
module curvature_oscillation_detector
  import cod_pkg::*;
#(
  parameter int LANES       = 4,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // conc_0 .. conc_(LANES-1), SAMPLE_BITS each, zero padded to bytes.
  input  wire logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // line_start, scan_start.
  input  wire logic [1:0]          s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // found_here, found_any, first_lane, zero padded to bytes.
  output logic [((2+((LANES>1)?$clog2(LANES):1)+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_BITS-1:0] cfg_data
);

  localparam int LANE_BITS = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int OUT_USED  = 2 + LANE_BITS;
  localparam int OUT_BITS  = ((OUT_USED + 7) / 8) * 8;

  logic [CFG_BITS-1:0]      substance_count;
  logic [LINE_POS_BITS-1:0] line_position;
  logic [LINE_POS_BITS-1:0] pos;
  logic                     accept;
  lane_ctrl_t               lane_ctrl;
  merge_ctrl_t              merge_ctrl;
  logic [LANES-1:0]         hits;
  logic                     found_here;
  logic                     found_any;
  logic [LANE_BITS-1:0]     first_lane;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pos                   = s_axis_tuser[0] ? '0 : line_position;
    lane_ctrl.accept      = accept;
    lane_ctrl.curve_en    = pos >= POS_CURVE;
    lane_ctrl.check_en    = pos >= POS_CHECK;
    merge_ctrl.accept     = accept;
    merge_ctrl.scan_start = s_axis_tuser[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      substance_count <= COUNT_RESET;
      line_position   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        substance_count <= cfg_data;
      end
      if (accept) begin
        line_position <= (pos < POS_MAX) ? pos + LINE_POS_BITS'(1) : POS_MAX;
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    cod_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk   (clk),
      .ctrl  (lane_ctrl),
      .enable(substance_count > CFG_BITS'(l)),
      .sample(s_axis_tdata[l*SAMPLE_BITS +: SAMPLE_BITS]),
      .hit   (hits[l])
    );
  end

  cod_merge #(
    .LANES    (LANES),
    .LANE_BITS(LANE_BITS)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (merge_ctrl),
    .hits          (hits),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_found_here(found_here),
    .out_found_any (found_any),
    .out_first_lane(first_lane)
  );

  assign m_axis_tdata[0]            = found_here;
  assign m_axis_tdata[1]            = found_any;
  assign m_axis_tdata[OUT_USED-1:2] = first_lane;
  if (OUT_BITS > OUT_USED) begin : g_pad
    assign m_axis_tdata[OUT_BITS-1:OUT_USED] = '0;
  end

endmodule
`default_nettype wire
